// ----- src/histogram_median_common_mode_assert.svh -----
// Assertion macros for the histogram median common-mode block.
// Depends on nothing; included by the top level only.
`ifndef HISTOGRAM_MEDIAN_COMMON_MODE_ASSERT_SVH
`define HISTOGRAM_MEDIAN_COMMON_MODE_ASSERT_SVH

// Implication in the same cycle.
`define HMCM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication in the next cycle.
`define HMCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/hmcm_pkg.sv -----
// Package for the histogram median common-mode block: constants, states, structs.
// Depends on nothing; used by every other file of the block except the assertion header.
`timescale 1ns / 1ps

package hmcm_pkg;

   localparam int MAX_FRAME_DEF   = 2048;
   localparam int SAMPLE_BITS_DEF = 10;
   localparam int CFG_BITS        = 12;
   localparam int CM_BITS         = 9;
   localparam int CORR_BITS       = 13;
   localparam int CM_MAX_QUARTERS = 499;
   localparam int FRAME_LEN_MIN   = 2;
   localparam logic [CFG_BITS-1:0] FRAME_LEN_RESET = 12'd1600;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_READ
   } state_type;

   // Head of the command queue as seen by the engine.
   typedef struct packed {
      logic valid;
      logic op;
   } head_type;

   // Engine status toward the front end.
   typedef struct packed {
      logic clearing;
      logic idle;
   } status_type;

endpackage

// ----- src/hmcm_if.sv -----
// Valid/ready channel interfaces for requests and responses.
// Depends on hmcm_pkg for field widths.
`timescale 1ns / 1ps

interface hmcm_req_if #(
   parameter int SAMPLE_BITS = hmcm_pkg::SAMPLE_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic                   op;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output op, output sample, input ready);
   modport sink   (input valid, input op, input sample, output ready);
endinterface

interface hmcm_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 median_ready;
   logic [hmcm_pkg::CM_BITS-1:0]         common_mode_quarters;
   logic                                 read_valid;
   logic signed [hmcm_pkg::CORR_BITS-1:0] corrected_quarters;
   logic                                 last_in_frame;

   modport source (output valid, output median_ready, output common_mode_quarters,
                   output read_valid, output corrected_quarters, output last_in_frame,
                   input ready);
   modport sink   (input valid, input median_ready, input common_mode_quarters,
                   input read_valid, input corrected_quarters, input last_in_frame,
                   output ready);
endinterface

// ----- src/hmcm_front.sv -----
// Front end: accepts request transfers into a two-entry command queue.
// Depends on hmcm_pkg and hmcm_if.
`timescale 1ns / 1ps

module hmcm_front #(
   parameter int SAMPLE_BITS = hmcm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   hmcm_req_if.sink                req_ch,
   input  hmcm_pkg::status_type    status,
   input  logic                    pop,
   output hmcm_pkg::head_type      head,
   output logic [SAMPLE_BITS-1:0]  head_sample
);

   logic [1:0]             vld_ff, vld_in;
   logic [1:0]             op_ff, op_in;
   logic [SAMPLE_BITS-1:0] smp_ff [2];
   logic [SAMPLE_BITS-1:0] smp_in [2];
   logic                   push;

   // Entry 0 is the head; entry 1 only fills behind it.
   assign req_ch.ready = !vld_ff[1] && !status.clearing;
   assign push         = req_ch.valid && req_ch.ready;
   assign head.valid   = vld_ff[0];
   assign head.op      = op_ff[0];
   assign head_sample  = smp_ff[0];

   always_comb begin
      vld_in = vld_ff;
      op_in  = op_ff;
      smp_in = smp_ff;
      if (pop) begin
         vld_in[0] = vld_ff[1];
         op_in[0]  = op_ff[1];
         smp_in[0] = smp_ff[1];
         vld_in[1] = 1'b0;
      end
      if (push) begin
         if (!vld_in[0]) begin
            vld_in[0] = 1'b1;
            op_in[0]  = req_ch.op;
            smp_in[0] = req_ch.sample;
         end else begin
            vld_in[1] = 1'b1;
            op_in[1]  = req_ch.op;
            smp_in[1] = req_ch.sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      op_ff  <= op_in;
      smp_ff <= smp_in;
   end

endmodule

// ----- src/hmcm_back.sv -----
// Back end: sample store, histogram memory, median scan and response register.
// Depends on hmcm_pkg and hmcm_if.
`timescale 1ns / 1ps

module hmcm_back #(
   parameter int MAX_FRAME   = hmcm_pkg::MAX_FRAME_DEF,
   parameter int SAMPLE_BITS = hmcm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [hmcm_pkg::CFG_BITS-1:0]     frame_length,
   input  hmcm_pkg::head_type                head,
   input  logic [SAMPLE_BITS-1:0]            head_sample,
   output logic                              pop,
   output hmcm_pkg::status_type              status,
   hmcm_rsp_if.source                        rsp_ch
);

   localparam int NUM_BINS = 2 ** SAMPLE_BITS;
   localparam int AW       = $clog2(MAX_FRAME);
   localparam int LCW      = $clog2(MAX_FRAME + 1);
   localparam int QW       = SAMPLE_BITS + 3;
   localparam int CB       = hmcm_pkg::CM_BITS;
   localparam int XB       = hmcm_pkg::CORR_BITS;

   hmcm_pkg::state_type state_ff, state_in;

   logic [LCW-1:0]         bin_mem [NUM_BINS];
   logic [SAMPLE_BITS-1:0] smp_mem [MAX_FRAME];
   logic [LCW-1:0]         bin_rdata_ff;
   logic [SAMPLE_BITS-1:0] smp_rdata_ff;

   logic                   bin_re, bin_we, smp_re, smp_we;
   logic [SAMPLE_BITS-1:0] bin_raddr, bin_waddr;
   logic [LCW-1:0]         bin_wdata;
   logic [AW-1:0]          smp_raddr;

   logic [LCW-1:0]         lc_ff, lc_in, rp_ff, rp_in, done_ff, done_in;
   logic [LCW-1:0]         n_ff, n_in, remain_ff, remain_in;
   logic [SAMPLE_BITS-1:0] k_ff, k_in, cur_ff, cur_in;
   logic [CB-1:0]          median_ff, median_in, cm_calc_ff, cm_calc_in;
   logic                   found_ff, found_in;

   logic                   out_valid_ff, out_valid_in;
   logic                   o_mr_ff, o_mr_in, o_rv_ff, o_rv_in, o_last_ff, o_last_in;
   logic [CB-1:0]          o_cm_ff, o_cm_in;
   logic [XB-1:0]          o_corr_ff, o_corr_in;

   logic                   out_free, take, rd_ok, k_last, lc_done, hit;
   logic [LCW-1:0]         n_eff, lc_next, rem_new;
   logic [31:0]            fl32;
   logic [LCW+1:0]         num, c1, c2, c3;
   logic [2:0]             frac;
   logic [QW-1:0]          q;
   logic [CB-1:0]          q_sat;

   // Effective frame length is the register clamped to the legal range.
   assign fl32  = 32'(frame_length);
   assign n_eff = (fl32 < 32'(hmcm_pkg::FRAME_LEN_MIN)) ? LCW'(hmcm_pkg::FRAME_LEN_MIN) :
                  (fl32 > 32'(MAX_FRAME)) ? LCW'(MAX_FRAME) : LCW'(fl32);

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign take     = (state_ff == hmcm_pkg::ST_IDLE) && head.valid && out_free;
   assign rd_ok    = rp_ff < done_ff;
   assign k_last   = k_ff == SAMPLE_BITS'(NUM_BINS - 1);
   assign lc_next  = lc_ff + LCW'(1);
   assign lc_done  = lc_next >= n_eff;

   // Scan step: remaining count, stop test and interpolation within the bin.
   assign rem_new = (bin_rdata_ff > remain_ff) ? '0 : remain_ff - bin_rdata_ff;
   assign hit     = !found_ff && (((LCW+1)'(rem_new) << 1) <= (LCW+1)'(n_ff));
   assign num     = ((LCW+2)'(remain_ff) << 2) - ((LCW+2)'(n_ff) << 1);
   assign c1      = (LCW+2)'(bin_rdata_ff);
   assign c2      = c1 << 1;
   assign c3      = c2 + c1;
   assign frac    = (num <= c1) ? 3'd1 : (num <= c2) ? 3'd2 : (num <= c3) ? 3'd3 : 3'd4;
   assign q       = ((QW)'(k_ff) << 2) + QW'(frac);
   assign q_sat   = (32'(q) > hmcm_pkg::CM_MAX_QUARTERS) ?
                    CB'(hmcm_pkg::CM_MAX_QUARTERS) : CB'(q);

   assign status.clearing = state_ff == hmcm_pkg::ST_CLEAR;
   assign status.idle     = state_ff == hmcm_pkg::ST_IDLE;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hmcm_pkg::ST_CLEAR: begin
            if (k_last) state_in = hmcm_pkg::ST_IDLE;
         end
         hmcm_pkg::ST_IDLE: begin
            if (take) begin
               if (head.op == hmcm_pkg::OP_LOAD) state_in = hmcm_pkg::ST_LOAD;
               else if (rd_ok) state_in = hmcm_pkg::ST_READ;
            end
         end
         hmcm_pkg::ST_LOAD: begin
            state_in = lc_done ? hmcm_pkg::ST_SCAN_RD : hmcm_pkg::ST_IDLE;
         end
         hmcm_pkg::ST_SCAN_RD: begin
            state_in = hmcm_pkg::ST_SCAN_EV;
         end
         hmcm_pkg::ST_SCAN_EV: begin
            state_in = k_last ? hmcm_pkg::ST_IDLE : hmcm_pkg::ST_SCAN_RD;
         end
         hmcm_pkg::ST_READ: begin
            state_in = hmcm_pkg::ST_IDLE;
         end
         default: begin
            state_in = hmcm_pkg::ST_CLEAR;
         end
      endcase
   end

   // Memory controls and queue pop.
   always_comb begin
      pop       = take;
      bin_re    = 1'b0;
      bin_raddr = head_sample;
      bin_we    = 1'b0;
      bin_waddr = k_ff;
      bin_wdata = '0;
      smp_we    = 1'b0;
      smp_re    = 1'b0;
      smp_raddr = rp_ff[AW-1:0];
      case (state_ff)
         hmcm_pkg::ST_CLEAR: begin
            bin_we = 1'b1;
         end
         hmcm_pkg::ST_IDLE: begin
            if (take && head.op == hmcm_pkg::OP_LOAD) begin
               bin_re = 1'b1;
               smp_we = 1'b1;
            end
            if (take && head.op == hmcm_pkg::OP_READ && rd_ok) smp_re = 1'b1;
         end
         hmcm_pkg::ST_LOAD: begin
            bin_we    = 1'b1;
            bin_waddr = cur_ff;
            bin_wdata = bin_rdata_ff + LCW'(1);
         end
         hmcm_pkg::ST_SCAN_RD: begin
            bin_re    = 1'b1;
            bin_raddr = k_ff;
         end
         hmcm_pkg::ST_SCAN_EV: begin
            // The scan empties each bin behind it for the next frame.
            bin_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Datapath registers.
   always_comb begin
      lc_in        = lc_ff;
      rp_in        = rp_ff;
      done_in      = done_ff;
      n_in         = n_ff;
      remain_in    = remain_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      median_in    = median_ff;
      cm_calc_in   = cm_calc_ff;
      found_in     = found_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      o_mr_in      = o_mr_ff;
      o_cm_in      = o_cm_ff;
      o_rv_in      = o_rv_ff;
      o_corr_in    = o_corr_ff;
      o_last_in    = o_last_ff;
      case (state_ff)
         hmcm_pkg::ST_CLEAR: begin
            k_in = k_ff + SAMPLE_BITS'(1);
         end
         hmcm_pkg::ST_IDLE: begin
            cur_in = head_sample;
            if (take && head.op == hmcm_pkg::OP_READ && !rd_ok) begin
               out_valid_in = 1'b1;
               o_mr_in      = 1'b0;
               o_cm_in      = '0;
               o_rv_in      = 1'b0;
               o_corr_in    = '0;
               o_last_in    = 1'b0;
            end
         end
         hmcm_pkg::ST_LOAD: begin
            if (lc_done) begin
               n_in       = lc_next;
               remain_in  = lc_next;
               done_in    = lc_next;
               lc_in      = '0;
               rp_in      = '0;
               k_in       = '0;
               found_in   = 1'b0;
               cm_calc_in = CB'(hmcm_pkg::CM_MAX_QUARTERS);
            end else begin
               lc_in        = lc_next;
               out_valid_in = 1'b1;
               o_mr_in      = 1'b0;
               o_cm_in      = '0;
               o_rv_in      = 1'b0;
               o_corr_in    = '0;
               o_last_in    = 1'b0;
            end
         end
         hmcm_pkg::ST_SCAN_EV: begin
            remain_in = rem_new;
            k_in      = k_ff + SAMPLE_BITS'(1);
            if (hit) begin
               found_in   = 1'b1;
               cm_calc_in = q_sat;
            end
            if (k_last) begin
               median_in    = hit ? q_sat : cm_calc_ff;
               out_valid_in = 1'b1;
               o_mr_in      = 1'b1;
               o_cm_in      = hit ? q_sat : cm_calc_ff;
               o_rv_in      = 1'b0;
               o_corr_in    = '0;
               o_last_in    = 1'b0;
            end
         end
         hmcm_pkg::ST_READ: begin
            rp_in        = rp_ff + LCW'(1);
            out_valid_in = 1'b1;
            o_mr_in      = 1'b0;
            o_cm_in      = '0;
            o_rv_in      = 1'b1;
            o_corr_in    = XB'(32'(smp_rdata_ff) << 2) - XB'(median_ff);
            o_last_in    = (rp_ff + LCW'(1)) == done_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hmcm_pkg::ST_CLEAR;
         k_ff         <= '0;
         lc_ff        <= '0;
         rp_ff        <= '0;
         done_ff      <= '0;
         median_ff    <= '0;
         found_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         lc_ff        <= lc_in;
         rp_ff        <= rp_in;
         done_ff      <= done_in;
         median_ff    <= median_in;
         found_ff     <= found_in;
         out_valid_ff <= out_valid_in;
      end
      n_ff       <= n_in;
      remain_ff  <= remain_in;
      cur_ff     <= cur_in;
      cm_calc_ff <= cm_calc_in;
      o_mr_ff    <= o_mr_in;
      o_cm_ff    <= o_cm_in;
      o_rv_ff    <= o_rv_in;
      o_corr_ff  <= o_corr_in;
      o_last_ff  <= o_last_in;
   end

   always_ff @(posedge clock) begin
      if (bin_we) bin_mem[bin_waddr] <= bin_wdata;
      if (bin_re) bin_rdata_ff <= bin_mem[bin_raddr];
   end

   always_ff @(posedge clock) begin
      if (smp_we) smp_mem[lc_ff[AW-1:0]] <= head_sample;
      if (smp_re) smp_rdata_ff <= smp_mem[smp_raddr];
   end

   assign rsp_ch.valid                = out_valid_ff;
   assign rsp_ch.median_ready         = o_mr_ff;
   assign rsp_ch.common_mode_quarters = o_cm_ff;
   assign rsp_ch.read_valid           = o_rv_ff;
   assign rsp_ch.corrected_quarters   = o_corr_ff;
   assign rsp_ch.last_in_frame        = o_last_ff;

endmodule

// ----- src/histogram_median_common_mode.sv -----
// A load reads its bin count and writes it back incremented before its response;
// a read fetches the stored sample first; a read past the frame is answered directly.
// The load that completes a frame adds a histogram scan that reads and evaluates
// each bin in turn before its response; the engine takes a new item only once it is back idle.
// Reset is synchronous: after it, a clearing pass of one bin per cycle runs while no
// request transfer is taken; the frame length returns to 1600.
`timescale 1ns / 1ps
`include "histogram_median_common_mode_assert.svh"

module histogram_median_common_mode #(
   parameter int MAX_FRAME   = hmcm_pkg::MAX_FRAME_DEF,
   parameter int SAMPLE_BITS = hmcm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   hmcm_req_if.sink                      req_ch,
   hmcm_rsp_if.source                    rsp_ch,
   input  logic                          csr_we,
   input  logic [hmcm_pkg::CFG_BITS-1:0] csr_wdata
);

   // Frame length register; the user must write it only while the block is quiet (the block does not enforce this).
   logic [hmcm_pkg::CFG_BITS-1:0] frame_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_len_ff <= hmcm_pkg::FRAME_LEN_RESET;
      end else if (csr_we) begin
         frame_len_ff <= csr_wdata;
      end
   end

   hmcm_pkg::status_type   status;
   hmcm_pkg::head_type     head;
   logic [SAMPLE_BITS-1:0] head_sample;
   logic                   pop;

   // The front end queues request transfers so the requester is not held
   // up while the engine finishes the previous item.
   hmcm_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .status      (status),
      .pop         (pop),
      .head        (head),
      .head_sample (head_sample)
   );

   // The engine owns both memories and a registered response stage; it takes the next
   // command only when that stage is empty or its response is transferred in that cycle.
   hmcm_back #(
      .MAX_FRAME   (MAX_FRAME),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .frame_length (frame_len_ff),
      .head         (head),
      .head_sample  (head_sample),
      .pop          (pop),
      .status       (status),
      .rsp_ch       (rsp_ch)
   );

   // A response never carries both a common mode and a corrected sample.
   `HMCM_ASSERT_NOW(a_one_kind, clock, reset, rsp_ch.valid, !(rsp_ch.median_ready && rsp_ch.read_valid), "response marks both median and read")
   // The common mode saturates at its ceiling.
   `HMCM_ASSERT_NOW(a_cm_sat, clock, reset, rsp_ch.valid && rsp_ch.median_ready, rsp_ch.common_mode_quarters <= hmcm_pkg::CM_MAX_QUARTERS, "common mode above ceiling")
   // No request transfer during the clearing pass.
   `HMCM_ASSERT_NOW(a_no_take_clear, clock, reset, status.clearing, !req_ch.ready, "request taken while clearing")
   // The last-in-frame flag only rides on a valid read.
   `HMCM_ASSERT_NOW(a_last_read, clock, reset, rsp_ch.valid && rsp_ch.last_in_frame, rsp_ch.read_valid, "last flag without read")

endmodule
